// ===== hdl/dtsa_pkg.sv =====
package dtsa_pkg;

   // Field widths fixed by the interface
   localparam int unsigned WIDTH_BITS  = 15;
   localparam int unsigned COORD_BITS  = 14;
   localparam int unsigned LEVEL_BITS  = 3;
   localparam int unsigned OFFSET_BITS = 30;

   // Tile geometry: 128x128 pixels of 4 bytes, 64 KiB per tile
   localparam int unsigned TILE_LOG2    = 7;
   localparam int unsigned TPR_BITS     = 9;   // ceil(32767 / 128) = 256
   localparam int unsigned INDEX_BITS   = 16;
   localparam int unsigned INTILE_BITS  = 16;
   localparam int unsigned INDEX_LIMIT  = 16384; // index * 64 KiB must stay below 2^30

   // Mip tail: 64x64 top level, levels 0 to 6
   localparam int unsigned TAIL_TOP    = 64;
   localparam logic [LEVEL_BITS-1:0] TAIL_LEVELS = 3'd7;

   typedef enum logic {
      CMD_SURFACE = 1'b0,
      CMD_TAIL    = 1'b1
   } command_type;

   typedef struct packed {
      command_type                 command;
      logic [COORD_BITS-1:0]       x_coord;
      logic [COORD_BITS-1:0]       y_coord;
      logic [LEVEL_BITS-1:0]       mip_level;
   } req_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0]      byte_offset;
      logic                        invalid;
   } rsp_type;

   // XOR masks selected by each of the low seven column bits
   function automatic logic [INTILE_BITS-1:0] col_mask(input logic [2:0] bit_no);
      case (bit_no)
         3'd0:    col_mask = 16'h0004;
         3'd1:    col_mask = 16'h0010;
         3'd2:    col_mask = 16'h0040;
         3'd3:    col_mask = 16'h0100;
         3'd4:    col_mask = 16'h2200;
         3'd5:    col_mask = 16'h0800;
         3'd6:    col_mask = 16'h8400;
         default: col_mask = 16'h0000;
      endcase
   endfunction

   // XOR masks selected by each of the low seven row bits
   function automatic logic [INTILE_BITS-1:0] row_mask(input logic [2:0] bit_no);
      case (bit_no)
         3'd0:    row_mask = 16'h0008;
         3'd1:    row_mask = 16'h0020;
         3'd2:    row_mask = 16'h0080;
         3'd3:    row_mask = 16'h1100;
         3'd4:    row_mask = 16'h0200;
         3'd5:    row_mask = 16'h0400;
         3'd6:    row_mask = 16'h4800;
         default: row_mask = 16'h0000;
      endcase
   endfunction

   // Offset inside one tile from the low seven bits of column and row
   function automatic logic [INTILE_BITS-1:0] in_tile_offset(
      input logic [TILE_LOG2-1:0] col,
      input logic [TILE_LOG2-1:0] row
   );
      logic [INTILE_BITS-1:0] acc;
      acc = '0;
      for (int b = 0; b < TILE_LOG2; b++) begin
         if (col[b]) acc = acc ^ col_mask(3'(b));
         if (row[b]) acc = acc ^ row_mask(3'(b));
      end
      return acc;
   endfunction

   // Placement of each mip-tail level inside its 128x128 tile
   function automatic logic [TILE_LOG2-1:0] tail_origin_x(input logic [LEVEL_BITS-1:0] lvl);
      case (lvl)
         3'd0:    tail_origin_x = 7'd64;
         3'd2:    tail_origin_x = 7'd32;
         3'd4:    tail_origin_x = 7'd16;
         3'd5:    tail_origin_x = 7'd8;
         default: tail_origin_x = 7'd0;
      endcase
   endfunction

   function automatic logic [TILE_LOG2-1:0] tail_origin_y(input logic [LEVEL_BITS-1:0] lvl);
      case (lvl)
         3'd1:    tail_origin_y = 7'd64;
         3'd3:    tail_origin_y = 7'd32;
         3'd5:    tail_origin_y = 7'd16;
         3'd6:    tail_origin_y = 7'd24;
         default: tail_origin_y = 7'd0;
      endcase
   endfunction

endpackage

// ===== hdl/depth_tile_swizzle_address_top.sv =====
// Depth tile address generator: turns a pixel coordinate of a 32-bit depth
// surface into the byte offset of its element in a 64 KiB tiled layout, or
// into the offset of a mip-tail pixel (levels 0 to 6 of a 64x64 chain packed
// into one tile). It takes one request per clock unless the response side stalls
// and returns one response per request, in order, through registered stages:
// decode and range checks, tile index multiply with the in-tile XOR swizzle,
// then the final range check in the output register. A stall holds every stage
// in place and empty stages still fill. surface_width must be written over the
// csr port only while no request is in flight; the block does not enforce this.
// It resets to zero, which makes every surface lookup invalid until programmed.
module depth_tile_swizzle_address_top
   import dtsa_pkg::*;
#(
   parameter int unsigned MAX_DIM = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WIDTH_BITS-1:0] csr_data
);

   localparam logic [16:0] MaxDimVal = 17'(MAX_DIM);

   // surface width register
   logic [WIDTH_BITS-1:0] width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // stage registers
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_ok_ff, s1_ok_in;
   logic [COORD_BITS-1:0]        s1_x_ff, s1_x_in;
   logic [COORD_BITS-1:0]        s1_y_ff, s1_y_in;
   logic [TPR_BITS-1:0]          s1_tpr_ff, s1_tpr_in;

   logic                         s2_valid_ff, s2_valid_in;
   logic                         s2_ok_ff, s2_ok_in;
   logic [INDEX_BITS-1:0]        s2_index_ff, s2_index_in;
   logic [INTILE_BITS-1:0]       s2_intile_ff, s2_intile_in;

   logic                         out_valid_ff, out_valid_in;
   rsp_type                      out_data_ff, out_data_in;

   // stall control: a stage moves when it is empty or the next one moves
   logic adv_out, adv_s2, adv_s1;

   assign adv_out   = !out_valid_ff || rsp_ready;
   assign adv_s2    = !s2_valid_ff || adv_out;
   assign adv_s1    = !s1_valid_ff || adv_s2;
   assign req_ready = adv_s1;

   // stage 1: range checks, tail placement, tiles per row
   logic [COORD_BITS-1:0] tail_size;
   logic [15:0]           width_round;
   logic                  surf_ok, tail_ok;

   always_comb begin
      tail_size   = 14'(TAIL_TOP) >> req_data.mip_level;
      width_round = 16'(width_ff) + 16'((1 << TILE_LOG2) - 1);
      surf_ok     = (width_ff != '0)
                 && ({2'b00, width_ff} <= MaxDimVal)
                 && ({1'b0, req_data.x_coord} < width_ff)
                 && ({3'b000, req_data.y_coord} < MaxDimVal);
      tail_ok     = (req_data.mip_level != TAIL_LEVELS)
                 && (req_data.x_coord < tail_size)
                 && (req_data.y_coord < tail_size);

      s1_valid_in = adv_s1 ? req_valid : s1_valid_ff;
      s1_ok_in    = s1_ok_ff;
      s1_x_in     = s1_x_ff;
      s1_y_in     = s1_y_ff;
      s1_tpr_in   = s1_tpr_ff;
      if (adv_s1) begin
         case (req_data.command)
            CMD_SURFACE: begin
               s1_ok_in  = surf_ok;
               s1_x_in   = req_data.x_coord;
               s1_y_in   = req_data.y_coord;
               s1_tpr_in = width_round[15:TILE_LOG2];
            end
            CMD_TAIL: begin
               // valid tail coordinates land inside the single tile
               s1_ok_in  = tail_ok;
               s1_x_in   = COORD_BITS'(tail_origin_x(req_data.mip_level)
                                     + req_data.x_coord[TILE_LOG2-1:0]);
               s1_y_in   = COORD_BITS'(tail_origin_y(req_data.mip_level)
                                     + req_data.y_coord[TILE_LOG2-1:0]);
               s1_tpr_in = TPR_BITS'(1);
            end
            default: begin
               s1_ok_in  = 1'b0;
               s1_x_in   = '0;
               s1_y_in   = '0;
               s1_tpr_in = '0;
            end
         endcase
      end
   end

   // stage 2: tile index and in-tile swizzle
   logic [INDEX_BITS-1:0] tile_prod;

   always_comb begin
      tile_prod    = INDEX_BITS'(s1_y_ff[COORD_BITS-1:TILE_LOG2]) * INDEX_BITS'(s1_tpr_ff);
      s2_valid_in  = adv_s2 ? s1_valid_ff : s2_valid_ff;
      s2_ok_in     = adv_s2 ? s1_ok_ff : s2_ok_ff;
      s2_index_in  = adv_s2 ? tile_prod + INDEX_BITS'(s1_x_ff[COORD_BITS-1:TILE_LOG2])
                            : s2_index_ff;
      s2_intile_in = adv_s2 ? in_tile_offset(s1_x_ff[TILE_LOG2-1:0], s1_y_ff[TILE_LOG2-1:0])
                            : s2_intile_ff;
   end

   // stage 3: offset must fit 30 bits; invalid results read as zero
   logic fits;

   always_comb begin
      fits         = s2_ok_ff && (s2_index_ff < INDEX_BITS'(INDEX_LIMIT));
      out_valid_in = adv_out ? s2_valid_ff : out_valid_ff;
      out_data_in  = out_data_ff;
      if (adv_out) begin
         out_data_in.invalid     = !fits;
         out_data_in.byte_offset = fits ? {s2_index_ff[OFFSET_BITS-INTILE_BITS-1:0],
                                           s2_intile_ff}
                                        : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ok_ff     <= s1_ok_in;
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      s1_tpr_ff    <= s1_tpr_in;
      s2_ok_ff     <= s2_ok_in;
      s2_index_ff  <= s2_index_in;
      s2_intile_ff <= s2_intile_in;
      out_data_ff  <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hdl/dtsa_checker.sv =====
module dtsa_checker
   import dtsa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an invalid response carries a zero offset
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid |-> rsp_data.byte_offset == '0)
      else $error("invalid response with non-zero offset");

   // nothing is presented straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an accepted request, once past the s1 and s2 registers, keeps the output stage occupied
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##3 rsp_valid)
      else $error("request lost in the pipeline");

   // a waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while waiting");

endmodule

bind depth_tile_swizzle_address_top dtsa_checker u_dtsa_checker (.*);

// ===== sim/depth_tile_swizzle_address_checker.sv =====
// Watches the request, response and csr channels of the depth tile address
// generator, predicts each response from the request and the programmed width,
// and compares responses in order against the predictions.
module depth_tile_swizzle_address_checker
   import dtsa_pkg::*;
#(
   parameter int unsigned MAX_DIM = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [WIDTH_BITS-1:0] csr_data,
   output int unsigned           outstanding,
   output int unsigned           fail_count,
   output int unsigned           lookup_count,
   output int unsigned           invalid_count,
   output int unsigned           tail_count
);

   localparam int unsigned TILE_DIM          = 1 << TILE_LOG2;
   localparam longint unsigned TILE_BYTES    = 64'h1_0000;
   localparam longint unsigned OFFSET_LIMIT  = 64'h4000_0000;
   localparam int unsigned PRINT_LIMIT       = 100;

   // Swizzle masks, entry 0 in the low 16 bits
   localparam logic [7*16-1:0] COL_XOR = {16'h8400, 16'h0800, 16'h2200, 16'h0100,
                                          16'h0040, 16'h0010, 16'h0004};
   localparam logic [7*16-1:0] ROW_XOR = {16'h4800, 16'h0400, 16'h0200, 16'h1100,
                                          16'h0080, 16'h0020, 16'h0008};
   // Tail level origins inside the tile, level 0 in the low 7 bits
   localparam logic [7*7-1:0] TAIL_X = {7'd0, 7'd8, 7'd16, 7'd0, 7'd32, 7'd0, 7'd64};
   localparam logic [7*7-1:0] TAIL_Y = {7'd24, 7'd16, 7'd0, 7'd32, 7'd0, 7'd64, 7'd0};

   rsp_type               expected_offsets[$];
   logic [WIDTH_BITS-1:0] programmed_width;
   int unsigned           response_count;

   initial begin
      outstanding    = 0;
      fail_count     = 0;
      lookup_count   = 0;
      invalid_count  = 0;
      tail_count     = 0;
      response_count = 0;
   end

   // Expected address for one lookup at the given surface width
   function automatic rsp_type predict_depth_address(input req_type lookup,
                                                     input logic [WIDTH_BITS-1:0] width);
      rsp_type           result;
      int unsigned       col;
      int unsigned       row;
      int unsigned       span;
      int unsigned       size;
      int unsigned       tiles_per_row;
      logic [15:0]       swizzle;
      longint unsigned   total;
      logic              ok;
      result = '0;
      col    = 32'(lookup.x_coord);
      row    = 32'(lookup.y_coord);
      span   = 32'(width);
      ok     = 1'b1;
      // a tail level sits at a fixed origin of one tile, seen as a 128 wide surface
      if (lookup.command == CMD_TAIL) begin
         if (lookup.mip_level >= TAIL_LEVELS) begin
            ok = 1'b0;
         end else begin
            size = TAIL_TOP >> lookup.mip_level;
            if (col >= size || row >= size) ok = 1'b0;
            col  = col + 32'(TAIL_X[7*lookup.mip_level +: 7]);
            row  = row + 32'(TAIL_Y[7*lookup.mip_level +: 7]);
            span = TILE_DIM;
         end
      end
      if (ok && (span == 0 || span > MAX_DIM || col >= span || row >= MAX_DIM)) ok = 1'b0;
      if (ok) begin
         swizzle = '0;
         for (int b = 0; b < TILE_LOG2; b++) begin
            if (col[b]) swizzle = swizzle ^ COL_XOR[16*b +: 16];
            if (row[b]) swizzle = swizzle ^ ROW_XOR[16*b +: 16];
         end
         tiles_per_row = (span + TILE_DIM - 1) / TILE_DIM;
         total = 64'(row / TILE_DIM);
         total = total * 64'(tiles_per_row) + 64'(col / TILE_DIM);
         total = total * TILE_BYTES + 64'(swizzle);
         if (total >= OFFSET_LIMIT) ok = 1'b0;
         else result.byte_offset = total[OFFSET_BITS-1:0];
      end
      result.invalid = !ok;
      return result;
   endfunction

   // One line per mismatch; printing stops after the first 100 so a dead block stays readable
   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Channel monitor: predict on request, compare on response
   always @(posedge clock) begin : monitor
      rsp_type expected;
      if (reset) begin
         expected_offsets.delete();
         programmed_width = '0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) programmed_width = csr_data;
         if (req_valid && req_ready) begin
            expected_offsets.push_back(predict_depth_address(req_data, programmed_width));
            lookup_count++;
            if (req_data.command == CMD_TAIL) tail_count++;
         end
         if (rsp_valid && rsp_ready) begin
            response_count++;
            if (expected_offsets.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request waiting", response_count));
            end else begin
               expected = expected_offsets.pop_front();
               if (expected.invalid) invalid_count++;
               if (rsp_data.byte_offset !== expected.byte_offset)
                  report_mismatch($sformatf("response %0d byte_offset %0h, expected %0h",
                                            response_count, rsp_data.byte_offset,
                                            expected.byte_offset));
               if (rsp_data.invalid !== expected.invalid)
                  report_mismatch($sformatf("response %0d invalid %b, expected %b",
                                            response_count, rsp_data.invalid,
                                            expected.invalid));
            end
         end
         outstanding <= expected_offsets.size();
      end
   end

endmodule

// ===== sim/depth_tile_swizzle_address_top_tb.sv =====
// Stimulus and verdict for the depth tile address generator; checking lives
// in the checker instance.
module depth_tile_swizzle_address_top_tb;
   import dtsa_pkg::*;

   localparam int unsigned MAX_DIM         = 16384;
   localparam int unsigned RANDOM_SEGMENTS = 16;
   localparam int unsigned SEGMENT_LOOKUPS = 72;
   localparam int unsigned DRAIN_CYCLES    = 8;

   typedef enum int {
      FLOW_STEADY,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mix_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [WIDTH_BITS-1:0] csr_data;

   int unsigned           sender_idle_pct;
   int unsigned           receiver_stall_pct;
   int unsigned           width_writes;
   logic [WIDTH_BITS-1:0] current_width;

   int unsigned           outstanding;
   int unsigned           fail_count;
   int unsigned           lookup_count;
   int unsigned           invalid_count;
   int unsigned           tail_count;

   depth_tile_swizzle_address_top #(
      .MAX_DIM (MAX_DIM)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   depth_tile_swizzle_address_checker #(
      .MAX_DIM (MAX_DIM)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .outstanding   (outstanding),
      .fail_count    (fail_count),
      .lookup_count  (lookup_count),
      .invalid_count (invalid_count),
      .tail_count    (tail_count)
   );

   always #10 clock = ~clock;

   // Response side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic req_type make_lookup(input command_type cmd, input int unsigned x,
                                            input int unsigned y, input int unsigned level);
      req_type lookup;
      lookup.command   = cmd;
      lookup.x_coord   = x[COORD_BITS-1:0];
      lookup.y_coord   = y[COORD_BITS-1:0];
      lookup.mip_level = level[LEVEL_BITS-1:0];
      return lookup;
   endfunction

   // Mostly in-range lookups, with edges and full-range noise mixed in
   function automatic req_type random_lookup(input logic [WIDTH_BITS-1:0] width);
      req_type     lookup;
      int unsigned size;
      int unsigned roll;
      lookup.command   = command_type'($urandom_range(1));
      lookup.x_coord   = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
      lookup.y_coord   = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
      lookup.mip_level = LEVEL_BITS'($urandom_range((1 << LEVEL_BITS) - 1));
      roll = $urandom_range(99);
      if (lookup.command == CMD_SURFACE) begin
         if (width != 0 && width <= MAX_DIM) begin
            if (roll < 70) lookup.x_coord = COORD_BITS'($urandom_range(32'(width) - 1));
            else if (roll < 80 && width < (1 << COORD_BITS))
               lookup.x_coord = COORD_BITS'(32'(width) - $urandom_range(1));
         end
      end else if (roll < 85) begin
         lookup.mip_level = LEVEL_BITS'($urandom_range(TAIL_LEVELS - 1));
         size = TAIL_TOP >> lookup.mip_level;
         lookup.x_coord = COORD_BITS'($urandom_range(size - 1));
         lookup.y_coord = COORD_BITS'($urandom_range(size - 1));
         if (roll < 8) lookup.x_coord = COORD_BITS'(size - $urandom_range(1));
         else if (roll < 16) lookup.y_coord = COORD_BITS'(size - $urandom_range(1));
      end
      return lookup;
   endfunction

   // Widths: the extremes first, then mostly legal random ones
   function automatic logic [WIDTH_BITS-1:0] segment_width(input int unsigned seg);
      case (seg)
         0:       return WIDTH_BITS'(1);
         1:       return WIDTH_BITS'(MAX_DIM);
         2:       return WIDTH_BITS'(0);
         3:       return WIDTH_BITS'((1 << WIDTH_BITS) - 1);
         4:       return WIDTH_BITS'(128);
         5:       return WIDTH_BITS'(MAX_DIM + 1);
         6:       return WIDTH_BITS'(129);
         7:       return WIDTH_BITS'(127);
         default: begin
            if ($urandom_range(99) < 85) return WIDTH_BITS'($urandom_range(MAX_DIM, 1));
            return WIDTH_BITS'($urandom_range((1 << WIDTH_BITS) - 1, MAX_DIM + 1));
         end
      endcase
   endfunction

   task automatic set_flow_mix(input flow_mix_type mix);
      case (mix)
         FLOW_STEADY: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         FLOW_SENDER_IDLE: begin
            sender_idle_pct    = 59;
            receiver_stall_pct = 0;
         end
         FLOW_RECEIVER_STALL: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 59;
         end
         default: begin
            sender_idle_pct    = 13;
            receiver_stall_pct = 13;
         end
      endcase
   endtask

   // Present one request, with random idle cycles ahead of it
   task automatic issue_lookup(input req_type lookup);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= lookup;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Width writes only once every response is back
   task automatic program_width(input logic [WIDTH_BITS-1:0] width);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= width;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      current_width = width;
      width_writes++;
   endtask

   // Run time limit
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      rsp_ready     <= 1'b0;
      csr_valid     <= 1'b0;
      csr_data      <= '0;
      current_width = '0;
      width_writes  = 0;
      set_flow_mix(FLOW_STEADY);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // width still zero from reset: surface invalid, tail unaffected
      issue_lookup(make_lookup(CMD_SURFACE, 0, 0, 7));
      issue_lookup(make_lookup(CMD_TAIL, 63, 63, 0));
      issue_lookup(make_lookup(CMD_TAIL, 0, 0, 7));

      // widest legal surface: corners and tile borders
      program_width(WIDTH_BITS'(MAX_DIM));
      issue_lookup(make_lookup(CMD_SURFACE, 0, 0, 0));
      issue_lookup(make_lookup(CMD_SURFACE, 16383, 16383, 7));
      issue_lookup(make_lookup(CMD_SURFACE, 127, 127, 0));
      issue_lookup(make_lookup(CMD_SURFACE, 128, 0, 0));
      issue_lookup(make_lookup(CMD_SURFACE, 0, 128, 0));
      issue_lookup(make_lookup(CMD_SURFACE, 16383, 0, 0));
      issue_lookup(make_lookup(CMD_SURFACE, 0, 16383, 0));

      // every tail level at its far corner, then just past the level size
      for (int lvl = 0; lvl < TAIL_LEVELS; lvl++)
         issue_lookup(make_lookup(CMD_TAIL, (TAIL_TOP >> lvl) - 1, (TAIL_TOP >> lvl) - 1, lvl));
      issue_lookup(make_lookup(CMD_TAIL, 64, 0, 0));
      issue_lookup(make_lookup(CMD_TAIL, 1, 0, 6));
      issue_lookup(make_lookup(CMD_TAIL, 0, 1, 6));

      // column at the width, and a width above the maximum
      program_width(WIDTH_BITS'(100));
      issue_lookup(make_lookup(CMD_SURFACE, 99, 5, 0));
      issue_lookup(make_lookup(CMD_SURFACE, 100, 5, 0));
      program_width(WIDTH_BITS'(MAX_DIM + 1));
      issue_lookup(make_lookup(CMD_SURFACE, 0, 0, 0));

      // random segments, each with its own width and flow-control mix
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         program_width(segment_width(seg));
         set_flow_mix(flow_mix_type'(seg % 4));
         for (int n = 0; n < SEGMENT_LOOKUPS; n++) issue_lookup(random_lookup(current_width));
      end

      wait_drained();
      set_flow_mix(FLOW_STEADY);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d lookups (%0d mip-tail, %0d flagged out of range) over %0d widths",
               lookup_count, tail_count, invalid_count, width_writes);
      $display("under steady flow, sender gaps, response stalls and both together.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
